FILE: hdl/frkw_pkg.sv
`timescale 1ns / 1ps
package frkw_pkg;

	localparam int RecStartW = 48;
	localparam int QDepth = 4;
	localparam int QPtrW = 2;
	localparam int QCntW = 3;

	typedef enum logic [2:0] {
		PH_HDR_MARK,
		PH_KEYWORD,
		PH_COUNT,
		PH_TYPE,
		PH_HDR_TAIL,
		PH_DATA_MARK,
		PH_DATA_SKIP,
		PH_ERROR
	} phase_t;

	localparam logic [2:0] TY_INTE = 3'd0;
	localparam logic [2:0] TY_REAL = 3'd1;
	localparam logic [2:0] TY_DOUB = 3'd2;
	localparam logic [2:0] TY_CHAR = 3'd3;
	localparam logic [2:0] TY_LOGI = 3'd4;
	localparam logic [2:0] TY_MESS = 3'd5;
	localparam int NumTypes = 6;

	localparam logic [1:0] ST_FOUND = 2'd0;
	localparam logic [1:0] ST_END = 2'd1;
	localparam logic [1:0] ST_BAD = 2'd2;
	localparam logic [1:0] ST_TRUNC = 2'd3;

	localparam logic [31:0] TypeName [NumTypes] = '{
		32'h494E5445, 32'h5245414C, 32'h444F5542,
		32'h43484152, 32'h4C4F4749, 32'h4D455353
	};

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} byte_req_t;

	typedef struct packed {
		logic [63:0]          keyword;
		logic [2:0]           type_code;
		logic [30:0]          element_count;
		logic [RecStartW-1:0] record_start;
		logic [31:0]          record_index;
		logic [1:0]           status;
	} result_t;

	typedef struct packed {
		logic    first_valid;
		result_t first;
		logic    second_valid;
		result_t second;
	} push_t;

	// Element count of a data record of len bytes for the given type.
	function automatic logic [31:0] elem_count(input logic [31:0] len, input logic [2:0] ty);
		logic [31:0] q;
		case (ty)
			TY_DOUB, TY_CHAR: q = len >> 3;
			TY_LOGI: q = len;
			default: q = len >> 2;
		endcase
		return q;
	endfunction

endpackage

FILE: hdl/fortran_record_keyword_scanner_unit.sv
`timescale 1ns / 1ps
// Scans a Fortran unformatted sequential file delivered one byte per request on
// the byte channel (byte_valid, byte_stall, byte_data). Set last_byte on the
// final byte of the file; the scanner then returns to its reset state for the
// next file, keeping only the byte order register.
// For every keyword found, an error, a truncated file or a clean end, one
// request leaves on the result channel (result_valid, result_stall, result_data).
// A byte that finishes a record and is also the last byte gives two results.
// The front parser takes one byte per cycle while byte_stall is low; its results
// reach the result channel through a registered four-entry queue.
// byte_stall is high while the queue holds three or more results, so the file
// streams at one byte per cycle as long as the receiver drains results.
// A stalled result holds its value until it is taken.
// cfg_wr_en with cfg_wr_data writes the byte order of the integer fields:
// 0 big-endian, 1 little-endian. Write it only between files.
// Reset (arst_n low) empties the queue, clears the parser and selects
// big-endian integers.
module fortran_record_keyword_scanner_unit #(
	parameter int POS_WIDTH = 48
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic                cfg_wr_data,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  frkw_pkg::byte_req_t byte_data,
	output logic                result_valid,
	input  logic                result_stall,
	output frkw_pkg::result_t   result_data
);

	frkw_pkg::push_t push;
	logic            space;

	frkw_front #(
		.POS_WIDTH(POS_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_data  (byte_data),
		.space      (space),
		.push       (push)
	);

	frkw_queue u_queue (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.space       (space),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_data (result_data)
	);

endmodule

FILE: hdl/frkw_front.sv
`timescale 1ns / 1ps
module frkw_front #(
	parameter int POS_WIDTH = 48
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic                cfg_wr_data,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  frkw_pkg::byte_req_t byte_data,
	input  logic                space,
	output frkw_pkg::push_t     push
);

	localparam int RsW = frkw_pkg::RecStartW;

	frkw_pkg::phase_t phase_q, phase_n;
	logic                 order_q;
	logic [2:0]           fbc_q, fbc_n;
	logic [31:0]          word_q, word_n;
	logic [63:0]          kw_q, kw_n;
	logic [30:0]          hlen_q, hlen_n;
	logic [2:0]           type_q, type_n;
	logic [32:0]          skip_q, skip_n;
	logic [31:0]          seen_q, seen_n;
	logic [POS_WIDTH-1:0] pos_q, pos_n;
	logic [POS_WIDTH-1:0] start_q, start_n;
	logic [31:0]          cnt_q, cnt_n;

	logic        accept;
	logic [7:0]  b;
	logic [31:0] word_int;
	logic        int_last;
	logic        bad;
	logic        done;
	logic [32:0] sum;

	assign byte_stall = !space;
	assign accept = byte_valid && space;
	assign b = byte_data.data_byte;
	assign word_int = order_q ? {b, word_q[31:8]} : {word_q[23:0], b};
	assign int_last = (fbc_q == 3'd3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= frkw_pkg::PH_HDR_MARK;
			order_q <= 1'b0;
			fbc_q <= '0;
			word_q <= '0;
			kw_q <= '0;
			hlen_q <= '0;
			type_q <= '0;
			skip_q <= '0;
			seen_q <= '0;
			pos_q <= '0;
			start_q <= '0;
			cnt_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				order_q <= cfg_wr_data;
			end
			phase_q <= phase_n;
			fbc_q <= fbc_n;
			word_q <= word_n;
			kw_q <= kw_n;
			hlen_q <= hlen_n;
			type_q <= type_n;
			skip_q <= skip_n;
			seen_q <= seen_n;
			pos_q <= pos_n;
			start_q <= start_n;
			cnt_q <= cnt_n;
		end
	end

	always_comb begin
		phase_n = phase_q;
		fbc_n = fbc_q;
		word_n = word_q;
		kw_n = kw_q;
		hlen_n = hlen_q;
		type_n = type_q;
		skip_n = skip_q;
		seen_n = seen_q;
		pos_n = pos_q;
		start_n = start_q;
		cnt_n = cnt_q;
		bad = 1'b0;
		done = 1'b0;
		sum = '0;
		push = '0;
		if (accept) begin
			if (phase_q != frkw_pkg::PH_ERROR && !(&pos_q)) begin
				pos_n = pos_q + 1'b1;
			end
			case (phase_q)
				frkw_pkg::PH_HDR_MARK: begin
					if (fbc_q == 3'd0) begin
						kw_n = '0;
						hlen_n = '0;
						type_n = '0;
						seen_n = '0;
					end
					word_n = word_int;
					fbc_n = int_last ? 3'd0 : fbc_q + 3'd1;
					if (int_last) begin
						phase_n = frkw_pkg::PH_KEYWORD;
					end
				end
				frkw_pkg::PH_KEYWORD: begin
					kw_n = {kw_q[55:0], b};
					if (fbc_q == 3'd7) begin
						fbc_n = 3'd0;
						phase_n = frkw_pkg::PH_COUNT;
					end else begin
						fbc_n = fbc_q + 3'd1;
					end
				end
				frkw_pkg::PH_COUNT: begin
					word_n = word_int;
					fbc_n = int_last ? 3'd0 : fbc_q + 3'd1;
					if (int_last) begin
						if (word_int[31]) begin
							bad = 1'b1;
						end else begin
							hlen_n = word_int[30:0];
							phase_n = frkw_pkg::PH_TYPE;
						end
					end
				end
				frkw_pkg::PH_TYPE: begin
					word_n = {word_q[23:0], b};
					if (fbc_q == 3'd3) begin
						fbc_n = 3'd0;
						bad = 1'b1;
						for (int i = 0; i < frkw_pkg::NumTypes; i++) begin
							if (word_n == frkw_pkg::TypeName[i]) begin
								type_n = 3'(i);
								bad = 1'b0;
							end
						end
						if (!bad) begin
							phase_n = frkw_pkg::PH_HDR_TAIL;
						end
					end else begin
						fbc_n = fbc_q + 3'd1;
					end
				end
				frkw_pkg::PH_HDR_TAIL: begin
					word_n = word_int;
					fbc_n = int_last ? 3'd0 : fbc_q + 3'd1;
					if (int_last) begin
						if (hlen_q == '0) begin
							done = 1'b1;
						end else begin
							phase_n = frkw_pkg::PH_DATA_MARK;
						end
					end
				end
				frkw_pkg::PH_DATA_MARK: begin
					word_n = word_int;
					fbc_n = int_last ? 3'd0 : fbc_q + 3'd1;
					if (int_last) begin
						if (word_int[31]) begin
							bad = 1'b1;
						end else begin
							sum = {1'b0, seen_q} + {1'b0, frkw_pkg::elem_count(word_int, type_q)};
							seen_n = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
							skip_n = {1'b0, word_int} + 33'd4;
							phase_n = frkw_pkg::PH_DATA_SKIP;
						end
					end
				end
				frkw_pkg::PH_DATA_SKIP: begin
					if (skip_q != '0) begin
						skip_n = skip_q - 33'd1;
					end
					if (skip_n == '0) begin
						if (seen_q >= {1'b0, hlen_q}) begin
							done = 1'b1;
						end else begin
							phase_n = frkw_pkg::PH_DATA_MARK;
						end
					end
				end
				default: begin
				end
			endcase

			if (bad) begin
				push.first_valid = 1'b1;
				push.first = '{keyword: kw_n, type_code: type_n, element_count: hlen_n,
					record_start: RsW'(start_q), record_index: cnt_q,
					status: frkw_pkg::ST_BAD};
				phase_n = frkw_pkg::PH_ERROR;
				fbc_n = 3'd0;
			end else if (done) begin
				push.first_valid = 1'b1;
				push.first = '{keyword: kw_n, type_code: type_n, element_count: hlen_n,
					record_start: RsW'(start_q), record_index: cnt_q,
					status: frkw_pkg::ST_FOUND};
				if (!(&cnt_q)) begin
					cnt_n = cnt_q + 32'd1;
				end
				start_n = pos_n;
				phase_n = frkw_pkg::PH_HDR_MARK;
				fbc_n = 3'd0;
			end

			if (byte_data.last_byte) begin
				if (phase_n == frkw_pkg::PH_ERROR) begin
				end else if (phase_n == frkw_pkg::PH_HDR_MARK && fbc_n == 3'd0) begin
					push.second_valid = 1'b1;
					push.second = '{keyword: '0, type_code: '0, element_count: '0,
						record_start: RsW'(start_n), record_index: cnt_n,
						status: frkw_pkg::ST_END};
				end else begin
					push.second_valid = 1'b1;
					push.second = '{keyword: kw_n, type_code: type_n, element_count: hlen_n,
						record_start: RsW'(start_n), record_index: cnt_n,
						status: frkw_pkg::ST_TRUNC};
				end
				phase_n = frkw_pkg::PH_HDR_MARK;
				fbc_n = '0;
				word_n = '0;
				kw_n = '0;
				hlen_n = '0;
				type_n = '0;
				skip_n = '0;
				seen_n = '0;
				pos_n = '0;
				start_n = '0;
				cnt_n = '0;
			end
		end
	end

endmodule

FILE: hdl/frkw_queue.sv
`timescale 1ns / 1ps
module frkw_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  frkw_pkg::push_t   push,
	output logic              space,
	output logic              result_valid,
	input  logic              result_stall,
	output frkw_pkg::result_t result_data
);

	localparam int Depth = frkw_pkg::QDepth;
	localparam int PtrW = frkw_pkg::QPtrW;
	localparam int CntW = frkw_pkg::QCntW;

	frkw_pkg::result_t slot_q [Depth];
	logic [PtrW-1:0] wp_q;
	logic [PtrW-1:0] rp_q;
	logic [CntW-1:0] count_q;
	logic            pop;
	logic [PtrW-1:0] wp_second;

	assign space = (count_q <= CntW'(Depth - 2));
	assign result_valid = (count_q != '0);
	assign result_data = slot_q[rp_q];
	assign pop = result_valid && !result_stall;
	assign wp_second = wp_q + PtrW'(push.first_valid);

	always_ff @(posedge clk) begin
		if (push.first_valid) begin
			slot_q[wp_q] <= push.first;
		end
		if (push.second_valid) begin
			slot_q[wp_second] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			count_q <= '0;
		end else begin
			wp_q <= wp_q + PtrW'(push.first_valid) + PtrW'(push.second_valid);
			rp_q <= rp_q + PtrW'(pop);
			count_q <= count_q + CntW'(push.first_valid) + CntW'(push.second_valid)
				- CntW'(pop);
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(Depth))
		else $error("result queue count exceeds its depth");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push.first_valid || push.second_valid) |-> count_q <= CntW'(Depth - 2))
		else $error("results pushed without room for two");

	a_ptr_count: assert property (@(posedge clk) disable iff (!arst_n)
		PtrW'(wp_q - rp_q) == count_q[PtrW-1:0])
		else $error("queue pointers disagree with the count");
`endif

endmodule
